### hw/rtl/pwm_divider_wrap_calculator_unit_assert.svh
// Assertion helpers, clocked on aclk and disabled while aresetn is low.
`ifndef PWM_DIVIDER_WRAP_CALCULATOR_UNIT_ASSERT_SVH
`define PWM_DIVIDER_WRAP_CALCULATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PWMDW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWMDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pwmdw_pkg.sv
`timescale 1ns / 1ps
package pwmdw_pkg;
    localparam int CLK_W             = 29;
    localparam int FREQ_W            = 28;
    localparam int LVL_W             = 17;
    localparam int WRAP_W            = 16;
    localparam int DINT_W            = 16;
    localparam int DFRAC_W           = 8;
    localparam int DIV_FRAC_BITS_DEF = 8;
    localparam int LOOP_PERIOD_W     = 18;
    localparam int NATIVE_PERIOD_SH  = 16;
    localparam int NATIVE_CODE_SH    = 12;
    localparam int NAT_FRAC_BITS     = 4;
    localparam int PROD_W            = LVL_W + WRAP_W;
    localparam int LVL_FRAC_BITS     = 16;

    localparam logic [CLK_W-1:0]         CLK_RESET       = CLK_W'(125000000);
    localparam logic [LOOP_PERIOD_W-1:0] LOOP_PERIOD     = LOOP_PERIOD_W'(131074);
    localparam logic [DINT_W-1:0]        NAT_SAT_INT     = DINT_W'(255);
    localparam logic [DFRAC_W-1:0]       NAT_SAT_FRAC    = DFRAC_W'(8'hF0);
    localparam logic [WRAP_W-1:0]        WRAP_MAX        = '1;
    localparam logic [WRAP_W-1:0]        WRAP_MIN        = WRAP_W'(1);
    localparam logic [PROD_W:0]          ROUND_HALF      = (PROD_W + 1)'(32768);

    typedef struct packed {
        logic              loop_mode;
        logic              below_one;
        logic              zero_freq;
        logic [LVL_W-1:0]  level_a;
        logic [LVL_W-1:0]  level_b;
    } side_t;
endpackage

### hw/rtl/pwmdw_prep.sv
`timescale 1ns / 1ps
module pwmdw_prep #(
    parameter int FRAC_BITS = pwmdw_pkg::DIV_FRAC_BITS_DEF,
    localparam int NUM_W = pwmdw_pkg::CLK_W + FRAC_BITS,
    localparam int DEN_W = pwmdw_pkg::FREQ_W + pwmdw_pkg::LOOP_PERIOD_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_loop,
    input  logic [pwmdw_pkg::FREQ_W-1:0] in_freq,
    input  logic [pwmdw_pkg::LVL_W-1:0]  in_la,
    input  logic [pwmdw_pkg::LVL_W-1:0]  in_lb,
    input  logic [pwmdw_pkg::CLK_W-1:0]  clk_hz,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [NUM_W-1:0]            out_num,
    output logic [DEN_W-1:0]            out_den,
    output pwmdw_pkg::side_t            out_side
);
    import pwmdw_pkg::*;

    logic              v1_reg, v2_reg, rdy1, rdy2;
    logic              loop1_reg;
    logic [FREQ_W-1:0] freq1_reg;
    logic [LVL_W-1:0]  la1_reg, lb1_reg;
    logic [CLK_W-1:0]  clk1_reg;
    logic [DEN_W-1:0]  dl1_reg, dl_next;
    logic [NUM_W-1:0]  num2_reg, num_next;
    logic [DEN_W-1:0]  den2_reg, den_next, den_nat;
    side_t             side2_reg, side_next;
    logic              below;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign dl_next  = DEN_W'(in_freq) * DEN_W'(LOOP_PERIOD);

    always_comb begin
        den_nat = DEN_W'(freq1_reg) << NATIVE_PERIOD_SH;
        below   = (freq1_reg != '0) &&
                  (loop1_reg ? (DEN_W'(clk1_reg) < dl1_reg) : (DEN_W'(clk1_reg) < den_nat));
        if (!loop1_reg && below) begin
            num_next = NUM_W'(clk1_reg) + NUM_W'(freq1_reg) - NUM_W'(1);
            den_next = DEN_W'(freq1_reg);
        end else if (!loop1_reg) begin
            num_next = NUM_W'(clk1_reg);
            den_next = DEN_W'(freq1_reg) << NATIVE_CODE_SH;
        end else if (below) begin
            num_next = NUM_W'(clk1_reg) + (NUM_W'(freq1_reg) << 1) - NUM_W'(1);
            den_next = DEN_W'(freq1_reg) << 1;
        end else begin
            num_next = NUM_W'(clk1_reg) << FRAC_BITS;
            den_next = dl1_reg;
        end
        side_next.loop_mode = loop1_reg;
        side_next.below_one = below;
        side_next.zero_freq = (freq1_reg == '0);
        side_next.level_a   = la1_reg;
        side_next.level_b   = lb1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            loop1_reg <= in_loop;
            freq1_reg <= in_freq;
            la1_reg   <= in_la;
            lb1_reg   <= in_lb;
            clk1_reg  <= clk_hz;
            dl1_reg   <= dl_next;
        end
        if (rdy2 && v1_reg) begin
            num2_reg  <= num_next;
            den2_reg  <= den_next;
            side2_reg <= side_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_num   = num2_reg;
    assign out_den   = den2_reg;
    assign out_side  = side2_reg;
endmodule

### hw/rtl/pwmdw_div.sv
`timescale 1ns / 1ps
module pwmdw_div #(
    parameter int FRAC_BITS = pwmdw_pkg::DIV_FRAC_BITS_DEF,
    localparam int NUM_W = pwmdw_pkg::CLK_W + FRAC_BITS,
    localparam int DEN_W = pwmdw_pkg::FREQ_W + pwmdw_pkg::LOOP_PERIOD_W,
    localparam int QUO_W = FRAC_BITS + 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  pwmdw_pkg::side_t in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QUO_W-1:0] out_quo,
    output logic             out_rem_nz,
    output pwmdw_pkg::side_t out_side
);
    import pwmdw_pkg::*;

    logic             v_reg    [QUO_W];
    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] sh_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    side_t            side_reg [QUO_W];

    logic             p_v    [QUO_W];
    logic [DEN_W-1:0] p_rem  [QUO_W];
    logic [QUO_W-1:0] p_sh   [QUO_W];
    logic [DEN_W-1:0] p_den  [QUO_W];
    side_t            p_side [QUO_W];
    logic [DEN_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] sh_next  [QUO_W];
    logic [QUO_W:0]   rdy;

    assign rdy[QUO_W] = out_ready;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign p_v[k]    = in_valid;
            assign p_rem[k]  = DEN_W'(in_num[NUM_W-1:QUO_W]);
            assign p_sh[k]   = in_num[QUO_W-1:0];
            assign p_den[k]  = in_den;
            assign p_side[k] = in_side;
        end else begin : g_next
            assign p_v[k]    = v_reg[k-1];
            assign p_rem[k]  = rem_reg[k-1];
            assign p_sh[k]   = sh_reg[k-1];
            assign p_den[k]  = den_reg[k-1];
            assign p_side[k] = side_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            trial       = {p_rem[k], p_sh[k][QUO_W-1]};
            ge          = trial >= {1'b0, p_den[k]};
            rem_next[k] = ge ? DEN_W'(trial - {1'b0, p_den[k]}) : DEN_W'(trial);
            sh_next[k]  = {p_sh[k][QUO_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= p_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && p_v[k]) begin
                rem_reg[k]  <= rem_next[k];
                sh_reg[k]   <= sh_next[k];
                den_reg[k]  <= p_den[k];
                side_reg[k] <= p_side[k];
            end
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[QUO_W-1];
    assign out_quo    = sh_reg[QUO_W-1];
    assign out_rem_nz = |rem_reg[QUO_W-1];
    assign out_side   = side_reg[QUO_W-1];
endmodule

### hw/rtl/pwmdw_post.sv
`timescale 1ns / 1ps
module pwmdw_post #(
    parameter int FRAC_BITS = pwmdw_pkg::DIV_FRAC_BITS_DEF,
    localparam int QUO_W = FRAC_BITS + 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [QUO_W-1:0]              in_quo,
    input  logic                          in_rem_nz,
    input  pwmdw_pkg::side_t              in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pwmdw_pkg::WRAP_W-1:0]  out_wrap,
    output logic [pwmdw_pkg::DINT_W-1:0]  out_dint,
    output logic [pwmdw_pkg::DFRAC_W-1:0] out_dfrac,
    output logic [pwmdw_pkg::WRAP_W-1:0]  out_cmp_a,
    output logic [pwmdw_pkg::WRAP_W-1:0]  out_cmp_b,
    output logic                          out_too_low
);
    import pwmdw_pkg::*;
    `include "pwm_divider_wrap_calculator_unit_assert.svh"

    localparam int LCODE_W = DINT_W + FRAC_BITS;

    logic               v1_reg, v2_reg, v3_reg, rdy1, rdy2, rdy3;
    logic [WRAP_W-1:0]  wrap1_reg, wrap2_reg, wrap3_reg, wrap_next;
    logic [DINT_W-1:0]  dint1_reg, dint2_reg, dint3_reg, dint_next;
    logic [DFRAC_W-1:0] dfrac1_reg, dfrac2_reg, dfrac3_reg, dfrac_next;
    logic               tl1_reg, tl2_reg, tl3_reg, tl_next;
    logic [LVL_W-1:0]   la1_reg, lb1_reg, lb_next;
    logic [PROD_W-1:0]  pa2_reg, pb2_reg;
    logic [WRAP_W-1:0]  ca_next, cb_next, ca3_reg, cb3_reg;
    logic [LCODE_W-1:0] qx;
    logic [PROD_W:0]    sa, sb;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        qx         = LCODE_W'(in_quo);
        wrap_next  = WRAP_MAX;
        dint_next  = DINT_W'(1);
        dfrac_next = '0;
        tl_next    = 1'b0;
        lb_next    = in_side.loop_mode ? '0 : in_side.level_b;
        if (in_side.zero_freq) begin
            tl_next = 1'b1;
        end else if (in_side.below_one) begin
            if (!in_side.loop_mode) begin
                wrap_next = (in_quo >= QUO_W'(2)) ? WRAP_W'(in_quo - QUO_W'(1)) : WRAP_MIN;
            end else begin
                wrap_next = (in_quo >= QUO_W'(3)) ? WRAP_W'(in_quo - QUO_W'(2)) : WRAP_MIN;
            end
        end else if (!in_side.loop_mode) begin
            tl_next    = (in_quo > QUO_W'(4095)) || ((in_quo == QUO_W'(4095)) && in_rem_nz);
            dint_next  = DINT_W'(in_quo[NATIVE_CODE_SH-1:NAT_FRAC_BITS]);
            dfrac_next = DFRAC_W'(in_quo[NAT_FRAC_BITS-1:0]) << (DFRAC_W - NAT_FRAC_BITS);
        end else begin
            tl_next    = (qx == '1) && in_rem_nz;
            dint_next  = qx[LCODE_W-1:FRAC_BITS];
            dfrac_next = DFRAC_W'(qx[FRAC_BITS-1:0]) << (DFRAC_W - FRAC_BITS);
        end
        if (tl_next) begin
            wrap_next = WRAP_MAX;
            if (in_side.loop_mode) begin
                dint_next  = '1;
                dfrac_next = DFRAC_W'({FRAC_BITS{1'b1}}) << (DFRAC_W - FRAC_BITS);
            end else begin
                dint_next  = NAT_SAT_INT;
                dfrac_next = NAT_SAT_FRAC;
            end
        end
    end

    always_comb begin
        sa      = (PROD_W + 1)'(pa2_reg) + ROUND_HALF;
        sb      = (PROD_W + 1)'(pb2_reg) + ROUND_HALF;
        ca_next = (sa[PROD_W:LVL_FRAC_BITS] > (PROD_W + 1 - LVL_FRAC_BITS)'(WRAP_MAX))
                  ? WRAP_MAX : WRAP_W'(sa[PROD_W:LVL_FRAC_BITS]);
        cb_next = (sb[PROD_W:LVL_FRAC_BITS] > (PROD_W + 1 - LVL_FRAC_BITS)'(WRAP_MAX))
                  ? WRAP_MAX : WRAP_W'(sb[PROD_W:LVL_FRAC_BITS]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            wrap1_reg  <= wrap_next;
            dint1_reg  <= dint_next;
            dfrac1_reg <= dfrac_next;
            tl1_reg    <= tl_next;
            la1_reg    <= in_side.level_a;
            lb1_reg    <= lb_next;
        end
        if (rdy2 && v1_reg) begin
            pa2_reg    <= PROD_W'(la1_reg) * PROD_W'(wrap1_reg);
            pb2_reg    <= PROD_W'(lb1_reg) * PROD_W'(wrap1_reg);
            wrap2_reg  <= wrap1_reg;
            dint2_reg  <= dint1_reg;
            dfrac2_reg <= dfrac1_reg;
            tl2_reg    <= tl1_reg;
        end
        if (rdy3 && v2_reg) begin
            ca3_reg    <= ca_next;
            cb3_reg    <= cb_next;
            wrap3_reg  <= wrap2_reg;
            dint3_reg  <= dint2_reg;
            dfrac3_reg <= dfrac2_reg;
            tl3_reg    <= tl2_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign out_wrap    = wrap3_reg;
    assign out_dint    = dint3_reg;
    assign out_dfrac   = dfrac3_reg;
    assign out_cmp_a   = ca3_reg;
    assign out_cmp_b   = cb3_reg;
    assign out_too_low = tl3_reg;

    `PWMDW_ASSERT_NOW(a_wrap_nonzero, v3_reg, wrap3_reg != '0, "wrap is zero")
    `PWMDW_ASSERT_NOW(a_sat_wrap, v3_reg && tl3_reg, wrap3_reg == WRAP_MAX, "saturated wrap")
    `PWMDW_ASSERT_NOW(a_dint_nonzero, v3_reg, dint3_reg != '0, "divider below one")
    `PWMDW_ASSERT_NEXT(a_advance, v2_reg && rdy3, v3_reg, "stage lost transaction")
endmodule

### hw/rtl/pwm_divider_wrap_calculator_unit.sv
`timescale 1ns / 1ps
// PWM clock divider and wrap calculator.
// Input channel (s_*): one transaction per requested PWM frequency, with
// the mode (0 native slice, 1 software loop) and two duty levels in Q16.
// Result channel (m_*): wrap value, divider integer and fraction (1/256),
// round(level*wrap) compares (B 0 in loop mode), divider saturation flag.
// cfg_wr_en / cfg_wr_data set the system clock in Hz; write it only while
// no transaction is in flight.
// The pipeline has two setup stages, one quotient bit per stage of the
// divider (DIVIDER_FRAC_BITS + 13 stages) and three stages for limits,
// duty multiply and rounding. One transaction is accepted per cycle
// unless a stalled receiver has filled every stage.
// Each stage has its own valid bit; when the receiver stalls, results pile
// up toward the output and bubbles are squeezed out, so the input keeps
// accepting until every stage is full.
// Reset empties the pipeline and sets the system clock to 125 MHz.
module pwm_divider_wrap_calculator_unit #(
    parameter int DIVIDER_FRAC_BITS = pwmdw_pkg::DIV_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pwmdw_pkg::CLK_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [pwmdw_pkg::FREQ_W-1:0]  s_freq_hz,
    input  logic [pwmdw_pkg::LVL_W-1:0]   s_level_a_q16,
    input  logic [pwmdw_pkg::LVL_W-1:0]   s_level_b_q16,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pwmdw_pkg::WRAP_W-1:0]  m_period_wrap,
    output logic [pwmdw_pkg::DINT_W-1:0]  m_divider_int,
    output logic [pwmdw_pkg::DFRAC_W-1:0] m_divider_frac,
    output logic [pwmdw_pkg::WRAP_W-1:0]  m_compare_a,
    output logic [pwmdw_pkg::WRAP_W-1:0]  m_compare_b,
    output logic                          m_freq_too_low
);
    import pwmdw_pkg::*;

    localparam int NUM_W = CLK_W + DIVIDER_FRAC_BITS;
    localparam int DEN_W = FREQ_W + LOOP_PERIOD_W;
    localparam int QUO_W = DIVIDER_FRAC_BITS + 13;

    logic [CLK_W-1:0] clk_hz_reg;
    logic             p_valid, p_ready, d_valid, d_ready;
    logic [NUM_W-1:0] p_num;
    logic [DEN_W-1:0] p_den;
    side_t            p_side, d_side;
    logic [QUO_W-1:0] d_quo;
    logic             d_rem_nz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= CLK_RESET;
        end else if (cfg_wr_en) begin
            clk_hz_reg <= cfg_wr_data;
        end
    end

    pwmdw_prep #(.FRAC_BITS(DIVIDER_FRAC_BITS)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_loop   (s_action),
        .in_freq   (s_freq_hz),
        .in_la     (s_level_a_q16),
        .in_lb     (s_level_b_q16),
        .clk_hz    (clk_hz_reg),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_num   (p_num),
        .out_den   (p_den),
        .out_side  (p_side)
    );

    pwmdw_div #(.FRAC_BITS(DIVIDER_FRAC_BITS)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (p_valid),
        .in_ready   (p_ready),
        .in_num     (p_num),
        .in_den     (p_den),
        .in_side    (p_side),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .out_quo    (d_quo),
        .out_rem_nz (d_rem_nz),
        .out_side   (d_side)
    );

    pwmdw_post #(.FRAC_BITS(DIVIDER_FRAC_BITS)) u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (d_valid),
        .in_ready    (d_ready),
        .in_quo      (d_quo),
        .in_rem_nz   (d_rem_nz),
        .in_side     (d_side),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_wrap    (m_period_wrap),
        .out_dint    (m_divider_int),
        .out_dfrac   (m_divider_frac),
        .out_cmp_a   (m_compare_a),
        .out_cmp_b   (m_compare_b),
        .out_too_low (m_freq_too_low)
    );
endmodule

### verif/pwm_divider_wrap_calculator_unit_test.sv
`timescale 1ns / 1ps
module pwm_divider_wrap_calculator_unit_test;
    import pwmdw_pkg::*;

    localparam int FRAC_BITS = DIV_FRAC_BITS_DEF;
    localparam int LATENCY = FRAC_BITS + 18;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              action;
        logic [FREQ_W-1:0] freq_hz;
        logic [LVL_W-1:0]  level_a;
        logic [LVL_W-1:0]  level_b;
    } request_t;

    typedef struct packed {
        logic [WRAP_W-1:0]  wrap;
        logic [DINT_W-1:0]  dint;
        logic [DFRAC_W-1:0] dfrac;
        logic [WRAP_W-1:0]  cmp_a;
        logic [WRAP_W-1:0]  cmp_b;
        logic               too_low;
    } setting_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CLK_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [FREQ_W-1:0] s_freq_hz = '0;
    logic [LVL_W-1:0] s_level_a_q16 = '0;
    logic [LVL_W-1:0] s_level_b_q16 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [WRAP_W-1:0] m_period_wrap;
    logic [DINT_W-1:0] m_divider_int;
    logic [DFRAC_W-1:0] m_divider_frac;
    logic [WRAP_W-1:0] m_compare_a;
    logic [WRAP_W-1:0] m_compare_b;
    logic m_freq_too_low;

    request_t pending_requests[$];
    setting_t expected_settings[$];
    logic [CLK_W-1:0] sys_clock_hz = CLK_RESET;
    logic s_taken = 1'b0;
    int send_idle_pct = 10;
    int recv_idle_pct = 48;
    int error_count = 0;
    int checked_count = 0;
    longint cycle_count = 0;

    pwm_divider_wrap_calculator_unit #(.DIVIDER_FRAC_BITS(FRAC_BITS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_freq_hz(s_freq_hz), .s_level_a_q16(s_level_a_q16),
        .s_level_b_q16(s_level_b_q16),
        .m_valid(m_valid), .m_ready(m_ready), .m_period_wrap(m_period_wrap),
        .m_divider_int(m_divider_int), .m_divider_frac(m_divider_frac),
        .m_compare_a(m_compare_a), .m_compare_b(m_compare_b),
        .m_freq_too_low(m_freq_too_low)
    );

    always #10 aclk = ~aclk;

    function automatic logic [WRAP_W-1:0] duty_compare(longint unsigned lvl,
                                                        longint unsigned wrap);
        longint unsigned v;
        v = (lvl * wrap + 32768) >> 16;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic setting_t pwm_setting(request_t r, logic [CLK_W-1:0] clk_hz);
        longint unsigned clk, freq, den, code, rem, num, c, maxcode, fmask;
        longint unsigned wrap, dint, dfrac;
        logic sat;
        setting_t s;
        clk = 64'(clk_hz);
        freq = 64'(r.freq_hz);
        wrap = 65535;
        dint = 1;
        dfrac = 0;
        sat = 1'b0;
        if (!r.action) begin
            den = freq * 65536;
            if (freq == 0) begin
                sat = 1'b1;
            end else if (clk < den) begin
                c = (clk + freq - 1) / freq;
                wrap = (c >= 2) ? c - 1 : 1;
            end else begin
                code = (clk * 16) / den;
                rem = (clk * 16) % den;
                if (code > 4095 || (code == 4095 && rem != 0)) begin
                    sat = 1'b1;
                end else begin
                    dint = code >> 4;
                    dfrac = (code & 15) << 4;
                end
            end
            if (sat) begin
                dint = 255;
                dfrac = 8'hF0;
            end
        end else begin
            den = freq * 131074;
            fmask = (64'd1 << FRAC_BITS) - 1;
            maxcode = (64'd65536 << FRAC_BITS) - 1;
            if (freq == 0) begin
                sat = 1'b1;
            end else if (clk < den) begin
                c = (clk + 2 * freq - 1) / (2 * freq);
                wrap = (c >= 3) ? c - 2 : 1;
            end else begin
                num = clk << FRAC_BITS;
                code = num / den;
                rem = num % den;
                if (code > maxcode || (code == maxcode && rem != 0)) begin
                    sat = 1'b1;
                end else begin
                    dint = code >> FRAC_BITS;
                    dfrac = (code & fmask) << (8 - FRAC_BITS);
                end
            end
            if (sat) begin
                dint = 65535;
                dfrac = fmask << (8 - FRAC_BITS);
            end
        end
        s.wrap = wrap[15:0];
        s.dint = dint[15:0];
        s.dfrac = dfrac[7:0];
        s.cmp_a = duty_compare(64'(r.level_a), wrap);
        s.cmp_b = r.action ? '0 : duty_compare(64'(r.level_b), wrap);
        s.too_low = sat;
        return s;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !s_taken) begin
            end else if (pending_requests.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                request_t r;
                r = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_action <= r.action;
                s_freq_hz <= r.freq_hz;
                s_level_a_q16 <= r.level_a;
                s_level_b_q16 <= r.level_b;
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            request_t r;
            r.action = s_action;
            r.freq_hz = s_freq_hz;
            r.level_a = s_level_a_q16;
            r.level_b = s_level_b_q16;
            expected_settings.push_back(pwm_setting(r, sys_clock_hz));
        end
        if (aresetn && m_valid && m_ready) begin
            setting_t got, want;
            got = '{m_period_wrap, m_divider_int, m_divider_frac,
                    m_compare_a, m_compare_b, m_freq_too_low};
            if (expected_settings.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction %p", $time, got);
            end else begin
                want = expected_settings.pop_front();
                checked_count++;
                if (got.wrap !== want.wrap)
                    $display("%0t: wrap expected %0d actual %0d", $time, want.wrap, got.wrap);
                if (got.dint !== want.dint)
                    $display("%0t: divider_int expected %0d actual %0d",
                             $time, want.dint, got.dint);
                if (got.dfrac !== want.dfrac)
                    $display("%0t: divider_frac expected %0d actual %0d",
                             $time, want.dfrac, got.dfrac);
                if (got.cmp_a !== want.cmp_a)
                    $display("%0t: compare_a expected %0d actual %0d",
                             $time, want.cmp_a, got.cmp_a);
                if (got.cmp_b !== want.cmp_b)
                    $display("%0t: compare_b expected %0d actual %0d",
                             $time, want.cmp_b, got.cmp_b);
                if (got.too_low !== want.too_low)
                    $display("%0t: freq_too_low expected %0d actual %0d",
                             $time, want.too_low, got.too_low);
                if (got !== want)
                    error_count++;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("pwm_divider_wrap_calculator_unit_test: FAIL");
            $finish;
        end
    end

    function automatic request_t random_request();
        request_t r;
        int pick;
        pick = $urandom_range(9);
        r.action = 1'($urandom_range(1));
        case (pick)
            0: r.freq_hz = FREQ_W'($urandom);
            1: r.freq_hz = FREQ_W'($urandom_range(16));
            2: r.freq_hz = FREQ_W'($urandom_range(2000));
            3, 4: r.freq_hz = FREQ_W'($urandom_range(200000));
            default: r.freq_hz = FREQ_W'($urandom_range(150000000));
        endcase
        pick = $urandom_range(9);
        r.level_a = (pick == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        r.level_b = (pick == 1) ? 17'($urandom) : 17'($urandom_range(65536));
        return r;
    endfunction

    task automatic wait_drain();
        while (pending_requests.size() > 0 || s_valid || expected_settings.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] hz);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        sys_clock_hz <= hz;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random(int count);
        repeat (count) pending_requests.push_back(random_request());
    endtask

    logic [CLK_W-1:0] clock_settings[6] = '{29'd125000000, 29'd1000000, 29'd300000000,
                                         29'h1FFFFFFF, 29'd0, 29'd48000000};

    initial begin
        request_t r;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (clock_settings[k]) begin
            if (k > 0) write_clock(clock_settings[k]);
            for (int j = 0; j < 24 && k == 0; j++) begin
                r.action = j[0];
                case (j >> 1)
                    0: r.freq_hz = 0;
                    1: r.freq_hz = 1;
                    2: r.freq_hz = 7;
                    3: r.freq_hz = 1907;
                    4: r.freq_hz = 1908;
                    5: r.freq_hz = 954;
                    6: r.freq_hz = 1000;
                    7: r.freq_hz = 62500000;
                    8: r.freq_hz = 150000000;
                    9: r.freq_hz = 28'hFFFFFFF;
                    10: r.freq_hz = 20000;
                    default: r.freq_hz = 125000000;
                endcase
                r.level_a = (j % 3 == 0) ? 17'd65536 : ((j % 3 == 1) ? 17'd0 : 17'h1FFFF);
                r.level_b = (j % 3 == 1) ? 17'd65536 : ((j % 3 == 2) ? 17'd32768 : 17'h1FFFF);
                pending_requests.push_back(r);
            end
            queue_random(k == 0 ? 800 : 220);
            wait_drain();
            if (k == 0) begin
                send_idle_pct = 48;
                recv_idle_pct = 10;
            end else if (k == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        $display("Checked %0d results across %0d system clock settings, both modes.",
                 checked_count, 6);
        if (error_count == 0 && expected_settings.size() == 0) begin
            $display("pwm_divider_wrap_calculator_unit_test: PASS");
        end else begin
            $display("pwm_divider_wrap_calculator_unit_test: FAIL");
        end
        $finish;
    end

endmodule
